FILE: hdl/set_assoc_lru_cache_sim_top_assert.svh
// Assertion macros for the cache model.
`ifndef SET_ASSOC_LRU_CACHE_SIM_TOP_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_SIM_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SACL_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sacl assertion failed");
// antecedent implies consequent in the next cycle
`define SACL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sacl assertion failed");
`else
`define SACL_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define SACL_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/sacl_pkg.sv
`default_nettype none
package sacl_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd2;

  localparam logic [2:0] RST_SET_BITS    = 3'd4;
  localparam logic [3:0] RST_WAYS        = 4'd1;
  localparam logic [4:0] RST_OFFSET_BITS = 5'd4;

  localparam int HITS_W      = 2;
  localparam int CNT_W       = 32;
  localparam int OUT_FIELD_W = HITS_W + 2 + 3 * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

endpackage
`default_nettype wire

FILE: hdl/sacl_tag_store.sv
`default_nettype none
// One row per set: the tags and valid bits of all ways. A per-row written
// flag (cleared by reset) makes never-written rows read as all invalid.
module sacl_tag_store #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 rd_en,
  input  wire logic                                 wr_en,
  input  wire logic [(MAX_SET_BITS > 0 ? MAX_SET_BITS : 1)-1:0] idx,
  input  wire logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  wr_tags,
  input  wire logic [MAX_WAYS-1:0]                  wr_vld,
  output logic      [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  rd_tags,
  output logic      [MAX_WAYS-1:0]                  rd_vld
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;

  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_mem [NUM_SETS];
  logic [MAX_WAYS-1:0]                 vld_mem [NUM_SETS];
  logic [NUM_SETS-1:0]                 written;
  logic [MAX_WAYS-1:0]                 vld_raw;
  logic                                row_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[idx] <= wr_tags;
      vld_mem[idx] <= wr_vld;
    end
    if (rd_en) begin
      rd_tags <= tag_mem[idx];
      vld_raw <= vld_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      row_ok  <= 1'b0;
    end else begin
      if (wr_en) written[idx] <= 1'b1;
      if (rd_en) row_ok <= written[idx];
    end
  end

  assign rd_vld = row_ok ? vld_raw : '0;

endmodule
`default_nettype wire

FILE: hdl/set_assoc_lru_cache_sim_top.sv
`default_nettype none
// Set-associative LRU cache hit/miss model, one item at a time.
// Per access: read, load, compares one way at a time until a hit or the last effective
// way, update; a modify adds a second scan + update (which hits way 0).
// The result is registered in the output register from the done state. A new input
// transaction is taken only in idle, after the last result is loaded; m_tready stalls delay it.
// Reset: sync, active high; clears counters, row written flags, FSM, m_tvalid; resets config.
`include "set_assoc_lru_cache_sim_top_assert.svh"
module set_assoc_lru_cache_sim_top #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // [0] func, [ADDR_WIDTH:1] address, rest zero
  input  wire logic [((ADDR_WIDTH + 8) / 8) * 8-1:0] s_tdata,
  // result stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // [1:0] hits_now, [2] missed, [3] evicted, [35:4] total_hits,
  // [67:36] total_misses, [99:68] total_evictions, [103:100] zero
  output logic [sacl_pkg::OUT_TDATA_W-1:0]         m_tdata,
  // configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import sacl_pkg::*;

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  // configuration registers
  logic [2:0] set_index_bits;
  logic [3:0] ways_in_use;
  logic [4:0] block_offset_bits;

  // sequencer
  state_t state, state_next;

  // item being worked on
  logic                   modify;
  logic                   second;
  logic [ADDR_WIDTH-1:0]  acc_tag;
  logic [SET_W-1:0]       acc_set;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] row_tag;
  logic [MAX_WAYS-1:0]    row_vld;
  logic [WAY_W-1:0]       way;
  logic                   hit_flag;
  logic [WAY_W-1:0]       hit_way;
  logic [HITS_W-1:0]      hits;
  logic                   missed;
  logic                   evicted;

  // running counters
  logic [CNT_W-1:0] hit_cnt;
  logic [CNT_W-1:0] miss_cnt;
  logic [CNT_W-1:0] evict_cnt;

  // tag store interface
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] rd_tags;
  logic [MAX_WAYS-1:0]                 rd_vld;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] new_tags;
  logic [MAX_WAYS-1:0]                 new_vld;

  logic                  in_accept;
  logic                  out_load;
  logic                  tag_match;
  logic [WAY_W-1:0]      last_way;
  logic [WAY_W-1:0]      pos;
  logic [2:0]            s_eff;
  logic [5:0]            sb;
  logic [ADDR_WIDTH-1:0] in_addr;
  logic [ADDR_WIDTH-1:0] off_shift;
  logic [ADDR_WIDTH+SET_W-1:0] off_ext;
  logic [SET_W-1:0]      set_mask;
  logic [SET_W-1:0]      set_calc;
  logic [ADDR_WIDTH-1:0] tag_calc;

  // ---------------------------------------------------------------------------
  // Configuration: ready out of reset, writes beyond the register list are dropped.
  // ---------------------------------------------------------------------------
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits    <= RST_SET_BITS;
      ways_in_use       <= RST_WAYS;
      block_offset_bits <= RST_OFFSET_BITS;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SET_BITS:    set_index_bits    <= cfg_data[2:0];
        REG_WAYS:        ways_in_use       <= cfg_data[3:0];
        REG_OFFSET_BITS: block_offset_bits <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Effective associativity: 0 acts as 1, clamp to MAX_WAYS.
  always_comb begin
    if (ways_in_use == 4'd0) begin
      last_way = '0;
    end else if (32'(ways_in_use) > 32'(MAX_WAYS)) begin
      last_way = WAY_W'(MAX_WAYS - 1);
    end else begin
      last_way = WAY_W'(ways_in_use - 4'd1);
    end
  end

  // ---------------------------------------------------------------------------
  // Address split at the input transaction. Shifts past the address width
  // give zero, which covers the wide-offset cases.
  // ---------------------------------------------------------------------------
  assign in_addr   = s_tdata[ADDR_WIDTH:1];
  assign s_eff     = (32'(set_index_bits) > 32'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS)
                                                               : set_index_bits;
  assign sb        = 6'(s_eff) + 6'(block_offset_bits);
  assign off_shift = in_addr >> block_offset_bits;
  assign off_ext   = {{SET_W{1'b0}}, off_shift};
  assign set_mask  = ~({SET_W{1'b1}} << s_eff);
  assign set_calc  = off_ext[SET_W-1:0] & set_mask;
  assign tag_calc  = in_addr >> sb;

  // ---------------------------------------------------------------------------
  // Shared tag comparator, one way per cycle.
  // ---------------------------------------------------------------------------
  assign tag_match = row_vld[way] && (row_tag[way] == acc_tag);

  // LRU reorder: ways 0..pos-1 move back by one, the tag goes to the front.
  assign pos = hit_flag ? hit_way : last_way;

  always_comb begin
    new_tags    = row_tag;
    new_vld     = row_vld;
    new_tags[0] = acc_tag;
    new_vld[0]  = 1'b1;
    for (int k = 1; k < MAX_WAYS; k++) begin
      if (WAY_W'(k) <= pos) begin
        new_tags[k] = row_tag[k-1];
        new_vld[k]  = row_vld[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign s_tready  = (state == ST_IDLE) && !rst;
  assign in_accept = s_tvalid && s_tready;
  assign out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_READ;
      ST_READ:   state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_SCAN;
      ST_SCAN:   if (tag_match || way == last_way) state_next = ST_UPDATE;
      ST_UPDATE: state_next = (modify && !second) ? ST_SCAN : ST_DONE;
      ST_DONE:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Item datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      modify  <= s_tdata[0];
      acc_tag <= tag_calc;
      acc_set <= set_calc;
      second  <= 1'b0;
      hits    <= '0;
    end
    case (state)
      ST_LOAD: begin
        row_tag <= rd_tags;
        row_vld <= rd_vld;
        way     <= '0;
      end
      ST_SCAN: begin
        hit_flag <= tag_match;
        hit_way  <= way;
        if (!tag_match && way != last_way) way <= way + WAY_W'(1);
      end
      ST_UPDATE: begin
        row_tag <= new_tags;
        row_vld <= new_vld;
        way     <= '0;
        second  <= 1'b1;
        if (hit_flag) hits <= hits + HITS_W'(1);
        if (!second) begin
          missed  <= !hit_flag;
          evicted <= !hit_flag && row_vld[last_way];
        end
      end
      default: ;
    endcase
  end

  // Saturating counters, updated on each update step (twice for a modify).
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      evict_cnt <= '0;
    end else if (state == ST_UPDATE) begin
      if (hit_flag) begin
        if (hit_cnt != CNT_MAX) hit_cnt <= hit_cnt + CNT_W'(1);
      end else begin
        if (miss_cnt != CNT_MAX) miss_cnt <= miss_cnt + CNT_W'(1);
        if (row_vld[last_way] && evict_cnt != CNT_MAX) begin
          evict_cnt <= evict_cnt + CNT_W'(1);
        end
      end
    end
  end

  // Output register: holds one finished result while the next item runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_TDATA_W'({evict_cnt, miss_cnt, hit_cnt, evicted, missed, hits});
    end
  end

  // ---------------------------------------------------------------------------
  // Tag store: read the set row, write the reordered row back.
  // ---------------------------------------------------------------------------
  sacl_tag_store #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .MAX_WAYS    (MAX_WAYS),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (state == ST_READ),
    .wr_en  (state == ST_UPDATE),
    .idx    (acc_set),
    .wr_tags(new_tags),
    .wr_vld (new_vld),
    .rd_tags(rd_tags),
    .rd_vld (rd_vld)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // the comparator never steps past the last used way
  `SACL_ASSERT_SAME(a_way_range, clk, rst, state == ST_SCAN, way <= last_way)
  // a second pass only happens for a modify
  `SACL_ASSERT_SAME(a_second_modify, clk, rst, state == ST_SCAN && second, modify)
  // counters move only on an update step
  `SACL_ASSERT_NEXT(a_cnt_hold, clk, rst, state != ST_UPDATE,
                    $stable(hit_cnt) && $stable(miss_cnt) && $stable(evict_cnt))

endmodule
`default_nettype wire
